@@ rtl/core/pslrl_pkg.sv @@
// Shared types and constants for the per-source sliding-log rate limiter.
// Holds the chain link word, the cell command word and the verdict codes.
// Depends on nothing; every other file imports it.
`default_nettype none

package pslrl_pkg;

  // Length of the sliding window in seconds, at 33 bits so the add never wraps.
  localparam logic [32:0] WINDOW_SECONDS = 33'(60 * 60);

  // Verdict codes returned with every result word.
  typedef enum logic [1:0] {
    VERDICT_DENIED     = 2'd0,
    VERDICT_GRANTED    = 2'd1,
    VERDICT_NOT_IPV4   = 2'd2,
    VERDICT_TABLE_FULL = 2'd3
  } verdict_t;

  // Word handed from one cell to the next on every cycle.
  typedef struct packed {
    logic       tok;
    logic       found;
    logic       free_seen;
    logic       granted;
    logic [4:0] cnt;
  } link_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic scan;
    logic decide;
    logic expire_all;
    logic expire_sel;
    logic free_empty;
    logic resolve;
    logic create;
    logic clear_sel;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/pslrl_cell.sv @@
// One source slot of the limiter: address, valid flag and a shifting stamp queue.
// Passes a token word to its right-hand neighbour every cycle.
// Depends on pslrl_pkg.
`default_nettype none

module pslrl_cell #(
  parameter int STAMPS = 16,
  parameter int CW     = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pslrl_pkg::cmd_t   cmd_i,
  input  pslrl_pkg::link_t  link_i,
  output pslrl_pkg::link_t  link_o,
  input  logic [31:0]       req_addr_i,
  input  logic [31:0]       req_now_i,
  input  logic [CW-1:0]     limit_i
);
  import pslrl_pkg::*;

  localparam int IW = (STAMPS > 1) ? $clog2(STAMPS) : 1;

  logic          valid_r;
  logic          sel_r;
  logic          cand_r;
  logic [31:0]   addr_r;
  logic [CW-1:0] count_r;
  logic [31:0]   stamps_r [STAMPS];
  link_t         link_r;
  link_t         link_nxt;

  logic hit;
  logic take_free;
  logic my_turn;
  logic grant;
  logic expired;
  logic pop;

  // Token arrival decisions during the lookup and decision passes.
  assign hit       = link_i.tok && cmd_i.scan && !link_i.found && valid_r &&
                     (addr_r == req_addr_i);
  assign take_free = link_i.tok && cmd_i.scan && !link_i.found && !valid_r &&
                     !link_i.free_seen;
  assign my_turn   = link_i.tok && cmd_i.decide && sel_r;
  assign grant     = my_turn && (count_r < limit_i);

  // The oldest stamp always sits in the first place of the queue.
  assign expired = ({1'b0, req_now_i} >= ({1'b0, stamps_r[0]} + WINDOW_SECONDS));
  assign pop     = (count_r != '0) && expired &&
                   ((cmd_i.expire_all && valid_r) || (cmd_i.expire_sel && sel_r));

  // Word for the neighbour.
  always_comb begin
    link_nxt = link_i;
    if (hit) begin
      link_nxt.found = 1'b1;
    end
    if (take_free) begin
      link_nxt.free_seen = 1'b1;
    end
    if (my_turn) begin
      link_nxt.granted = grant;
      link_nxt.cnt     = grant ? 5'(count_r + CW'(1)) : 5'(count_r);
    end
  end

  // Slot control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
      cand_r  <= 1'b0;
      count_r <= '0;
      link_r  <= '0;
    end else begin
      link_r <= link_nxt;
      if (hit) begin
        sel_r <= 1'b1;
      end
      if (take_free) begin
        cand_r <= 1'b1;
      end
      if (cmd_i.resolve) begin
        cand_r <= 1'b0;
        if (cmd_i.create && cand_r) begin
          valid_r <= 1'b1;
          sel_r   <= 1'b1;
        end
      end
      if (cmd_i.clear_sel) begin
        sel_r <= 1'b0;
      end
      if (cmd_i.free_empty && valid_r && (count_r == '0)) begin
        valid_r <= 1'b0;
      end
      if (cmd_i.resolve && cmd_i.create && cand_r) begin
        count_r <= '0;
      end else if (pop) begin
        count_r <= count_r - CW'(1);
      end else if (grant) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Address and stamp queue; pops shift towards the head.
  always_ff @(posedge clk) begin
    if (cmd_i.resolve && cmd_i.create && cand_r) begin
      addr_r <= req_addr_i;
    end
    if (pop) begin
      for (int j = 0; j < STAMPS - 1; j++) begin
        stamps_r[j] <= stamps_r[j+1];
      end
    end else if (grant) begin
      stamps_r[count_r[IW-1:0]] <= req_now_i;
    end
  end

  assign link_o = link_r;

endmodule

`default_nettype wire

@@ rtl/core/per_source_sliding_log_rate_limiter.sv @@
// Per-source IPv4 request limiter: one request word in, one verdict word out.
// A row of SOURCES slots is walked by a token; the sequencer here drives them.
// Channels: in_* (source address, IPv4 flag, time) and out_* (verdict, live
// count) use valid/stall; a word moves at an edge with valid high, stall low.
// The APB port holds request_limit at byte address 0.
// Timing: one request at a time. A request takes the lookup walk, an expiry
// pass on its own slot, the decision walk and the done state; a table-full
// request ends after the lookup walk. Every SWEEP_PERIOD-th request first
// expires all slots in parallel and frees empty ones, then skips the slot's
// own expiry pass. A request that is not IPv4 finishes without the walks.
// The token walks move one slot per cycle.
// Reset empties the table, clears the sweep counter and the limit.
// While the receiver stalls, the finished word waits in the output register
// and the block holds its next result; in_stall is high while busy.
`default_nettype none

module per_source_sliding_log_rate_limiter #(
  parameter int SOURCES           = 16,
  parameter int STAMPS_PER_SOURCE = 16,
  parameter int SWEEP_PERIOD      = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_source_address,
  input  logic        in_is_ipv4,
  input  logic [31:0] in_time_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_verdict,
  output logic [4:0]  out_live_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pslrl_pkg::*;

  localparam int CW = $clog2(STAMPS_PER_SOURCE + 1);
  localparam int IW = (STAMPS_PER_SOURCE > 1) ? $clog2(STAMPS_PER_SOURCE) : 1;
  localparam int SW = (SWEEP_PERIOD > 1) ? $clog2(SWEEP_PERIOD) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWEEP, ST_FREE, ST_SCAN0, ST_SCAN, ST_RESOLVE,
    ST_EXPIRE, ST_DEC0, ST_DEC, ST_DONE
  } state_t;

  state_t        state_r;
  logic [SW-1:0] sweep_cnt_r;
  logic [IW-1:0] step_r;
  logic [31:0]   addr_q_r;
  logic [31:0]   now_q_r;
  logic          ipv4_r;
  logic          sweep_due_r;
  logic          found_r;
  logic          free_r;
  verdict_t      res_verdict_r;
  logic [4:0]    res_cnt_r;
  logic          out_valid_r;
  verdict_t      out_verdict_r;
  logic [4:0]    out_cnt_r;
  logic [4:0]    limit_r;

  logic          in_take;
  logic          sweep_wrap;
  logic [CW-1:0] limit_eff;
  cmd_t          cmd;
  link_t         chain [SOURCES+1];

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      limit_r <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, limit_r} : 32'd0;
  assign pready = 1'b1;

  // Limit saturates at the queue depth.
  assign limit_eff = (32'(limit_r) > 32'(STAMPS_PER_SOURCE)) ?
                     CW'(STAMPS_PER_SOURCE) : CW'(limit_r);

  assign in_stall   = (state_r != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign sweep_wrap = (sweep_cnt_r == SW'(SWEEP_PERIOD - 1));

  // Broadcast command decoded from the sequencer state.
  always_comb begin
    cmd            = '0;
    cmd.scan       = (state_r == ST_SCAN0) || (state_r == ST_SCAN);
    cmd.decide     = (state_r == ST_DEC0) || (state_r == ST_DEC);
    cmd.expire_all = (state_r == ST_SWEEP);
    cmd.expire_sel = (state_r == ST_EXPIRE);
    cmd.free_empty = (state_r == ST_FREE);
    cmd.resolve    = (state_r == ST_RESOLVE);
    cmd.create     = !found_r && free_r;
    cmd.clear_sel  = (state_r == ST_DONE);
  end

  // Token injection at the head of the row.
  always_comb begin
    chain[0]     = '0;
    chain[0].tok = (state_r == ST_SCAN0) || (state_r == ST_DEC0);
  end

  // The row of source slots.
  for (genvar i = 0; i < SOURCES; i++) begin : g_cell
    pslrl_cell #(
      .STAMPS (STAMPS_PER_SOURCE),
      .CW     (CW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd_i      (cmd),
      .link_i     (chain[i]),
      .link_o     (chain[i+1]),
      .req_addr_i (addr_q_r),
      .req_now_i  (now_q_r),
      .limit_i    (limit_eff)
    );
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sweep_cnt_r <= '0;
      step_r      <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The done state handles the output register itself.
      if (out_valid_r && !out_stall && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            addr_q_r    <= in_source_address;
            now_q_r     <= in_time_now;
            ipv4_r      <= in_is_ipv4;
            sweep_due_r <= sweep_wrap;
            sweep_cnt_r <= sweep_wrap ? '0 : sweep_cnt_r + SW'(1);
            step_r      <= '0;
            if (sweep_wrap) begin
              state_r <= ST_SWEEP;
            end else if (in_is_ipv4) begin
              state_r <= ST_SCAN0;
            end else begin
              res_verdict_r <= VERDICT_NOT_IPV4;
              res_cnt_r     <= '0;
              state_r       <= ST_DONE;
            end
          end
        end
        ST_SWEEP: begin
          step_r <= step_r + IW'(1);
          if (step_r == IW'(STAMPS_PER_SOURCE - 1)) begin
            state_r <= ST_FREE;
          end
        end
        ST_FREE: begin
          if (ipv4_r) begin
            state_r <= ST_SCAN0;
          end else begin
            res_verdict_r <= VERDICT_NOT_IPV4;
            res_cnt_r     <= '0;
            state_r       <= ST_DONE;
          end
        end
        ST_SCAN0: begin
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (chain[SOURCES].tok) begin
            found_r <= chain[SOURCES].found;
            free_r  <= chain[SOURCES].free_seen;
            state_r <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          step_r <= '0;
          if (!found_r && !free_r) begin
            res_verdict_r <= VERDICT_TABLE_FULL;
            res_cnt_r     <= '0;
            state_r       <= ST_DONE;
          end else if (sweep_due_r) begin
            state_r <= ST_DEC0;
          end else begin
            state_r <= ST_EXPIRE;
          end
        end
        ST_EXPIRE: begin
          step_r <= step_r + IW'(1);
          if (step_r == IW'(STAMPS_PER_SOURCE - 1)) begin
            state_r <= ST_DEC0;
          end
        end
        ST_DEC0: begin
          state_r <= ST_DEC;
        end
        ST_DEC: begin
          if (chain[SOURCES].tok) begin
            res_verdict_r <= chain[SOURCES].granted ? VERDICT_GRANTED : VERDICT_DENIED;
            res_cnt_r     <= chain[SOURCES].cnt;
            state_r       <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_verdict_r <= res_verdict_r;
            out_cnt_r     <= res_cnt_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = out_verdict_r;
  assign out_live_count = out_cnt_r;

endmodule

`default_nettype wire

@@ rtl/core/pslrl_chk.sv @@
// Port-level checks for the rate limiter, attached to the top level by bind.
// Depends on pslrl_pkg and the top level's port list.
`default_nettype none

module pslrl_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_verdict,
  input logic [4:0] out_live_count
);
  import pslrl_pkg::*;

  // Error verdicts never report stamps.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict == VERDICT_NOT_IPV4 || out_verdict == VERDICT_TABLE_FULL)
    |-> out_live_count == 5'd0)
    else $error("error verdict with non-zero live count");

  // A grant always leaves at least one stamp.
  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_GRANTED |-> out_live_count != 5'd0)
    else $error("grant with zero live count");

  // One request at a time: an accepted word makes the input busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not busy after accepting a word");

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_verdict) && $stable(out_live_count))
    else $error("stalled result word changed");

endmodule

bind per_source_sliding_log_rate_limiter pslrl_chk u_pslrl_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_verdict    (out_verdict),
  .out_live_count (out_live_count)
);

`default_nettype wire

@@ sim/tb_per_source_sliding_log_rate_limiter.sv @@
// Testbench for the per-source sliding-log rate limiter: random and directed
// request words, checked against a scoreboard that models the source table.
// Depends on pslrl_pkg and the per_source_sliding_log_rate_limiter RTL.
`timescale 1ns / 100ps

import pslrl_pkg::*;

// Scoreboard: holds its own copy of the source table and the expected results.
class limiter_scoreboard;
  logic [31:0] addr_tab [16];
  bit          live [16];
  int          cnt [16];
  int          head [16];
  logic [31:0] stamps [16][16];
  int          sweep_cnt;
  int          limit;
  verdict_t    exp_verdict [$];
  logic [4:0]  exp_count [$];
  int          errors;

  function void clear();
    for (int i = 0; i < 16; i++) begin
      live[i] = 0; cnt[i] = 0; head[i] = 0;
    end
    sweep_cnt = 0;
    limit = 0;
  endfunction

  function void drop_old(int s, logic [31:0] now);
    while (cnt[s] > 0) begin
      if ({1'b0, now} >= {1'b0, stamps[s][head[s]]} + WINDOW_SECONDS) begin
        head[s] = (head[s] + 1) % 16;
        cnt[s]--;
      end else begin
        break;
      end
    end
  endfunction

  // Works out the verdict for one accepted request word.
  function void note_request(logic [31:0] addr, logic v4, logic [31:0] now);
    bit sweep;
    int slot;
    int lim;
    sweep_cnt = (sweep_cnt + 1) % 64;
    sweep = (sweep_cnt == 0);
    if (sweep) begin
      for (int i = 0; i < 16; i++) begin
        if (live[i]) begin
          drop_old(i, now);
          if (cnt[i] == 0) begin
            live[i] = 0; head[i] = 0;
          end
        end
      end
    end
    if (!v4) begin
      exp_verdict.push_back(VERDICT_NOT_IPV4); exp_count.push_back(5'd0);
      return;
    end
    slot = -1;
    for (int i = 0; i < 16; i++) begin
      if (live[i] && addr_tab[i] == addr) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      for (int i = 0; i < 16; i++) begin
        if (!live[i]) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        exp_verdict.push_back(VERDICT_TABLE_FULL); exp_count.push_back(5'd0);
        return;
      end
      live[slot] = 1; addr_tab[slot] = addr; cnt[slot] = 0; head[slot] = 0;
    end
    if (!sweep) drop_old(slot, now);
    lim = (limit > 16) ? 16 : limit;
    if (cnt[slot] >= lim) begin
      exp_verdict.push_back(VERDICT_DENIED); exp_count.push_back(5'(cnt[slot]));
    end else begin
      stamps[slot][(head[slot] + cnt[slot]) % 16] = now;
      cnt[slot]++;
      exp_verdict.push_back(VERDICT_GRANTED); exp_count.push_back(5'(cnt[slot]));
    end
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // Compares one result word with the oldest expectation.
  task check_result(logic [1:0] verdict, logic [4:0] count);
    if (exp_verdict.size() == 0) begin
      report($sformatf("unexpected result verdict=%0d count=%0d", verdict, count));
      return;
    end
    if (verdict !== exp_verdict[0])
      report($sformatf("verdict %0d, expected %0d", verdict, exp_verdict[0]));
    if (count !== exp_count[0])
      report($sformatf("live count %0d, expected %0d", count, exp_count[0]));
    void'(exp_verdict.pop_front());
    void'(exp_count.pop_front());
  endtask
endclass

module tb_per_source_sliding_log_rate_limiter;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_source_address = 0;
  logic        in_is_ipv4 = 0;
  logic [31:0] in_time_now = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_verdict;
  logic [4:0]  out_live_count;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  limiter_scoreboard board;
  logic [31:0] clock_now;
  logic [31:0] addr_pool [8];
  int          hold_off;
  int          cycles;

  per_source_sliding_log_rate_limiter u_top (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // Long-run guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("tb_per_source_sliding_log_rate_limiter failed");
      $finish;
    end
  end

  // Receiver: random stall, plus one long hold-off when asked for.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_verdict, out_live_count);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 9) < 2) begin
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) == 0);
    end
  end

  // Stops offering and waits until every expected result has been seen.
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (board.exp_verdict.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  task automatic write_limit(int value);
    drain();
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= 3'd0; pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.limit = value & 5'h1f;
  endtask

  // Offers one request word and waits for it to be taken.
  task automatic send(logic [31:0] addr, logic v4, logic [31:0] now);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_source_address <= addr; in_is_ipv4 <= v4; in_time_now <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(addr, v4, now);
  endtask

  task automatic random_phase(int n);
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: clock_now = clock_now + $urandom_range(3000, 4000);
        1: clock_now = clock_now + $urandom_range(0, 600);
        default: clock_now = clock_now + $urandom_range(0, 40);
      endcase
      a = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[$urandom_range(0, 7)];
      send(a, $urandom_range(0, 15) != 0, clock_now);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    board.errors = 0;
    cycles = 0;
    hold_off = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Directed: limit zero, field extremes, not IPv4, table full, expiry.
    send(32'h0, 1, 32'h0);
    send(32'hffffffff, 0, 32'h0);
    write_limit(2);
    send(32'hffffffff, 1, 32'd10);
    send(32'hffffffff, 1, 32'd11);
    send(32'hffffffff, 1, 32'd12);
    send(32'hffffffff, 1, 32'd5);
    send(32'hffffffff, 1, 32'd3610);
    for (int i = 0; i < 16; i++) send(32'h0a000000 + i, 1, 32'd3620);
    send(32'hffffffff, 1, 32'hfffffff0);
    drain();
    write_limit(31);
    for (int i = 0; i < 18; i++) send(32'h12345678, 1, 32'hfffffff0);
    drain();

    // Random phases over several limits; time starts near the top and wraps
    // past zero; reset is never re-entered, so time keeps running upwards.
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    clock_now = 32'hfffffff0;
    write_limit(16);
    random_phase(300);
    drain();
    write_limit(0);
    random_phase(100);
    drain();
    write_limit($urandom_range(1, 15));
    hold_off = 400;
    random_phase(400);
    drain();
    write_limit(17);
    for (int i = 0; i < 8; i++) addr_pool[i] = $urandom;
    random_phase(400);
    drain();

    if (board.errors == 0 && board.exp_verdict.size() == 0) begin
      $display("tb_per_source_sliding_log_rate_limiter passed");
    end else begin
      $display("tb_per_source_sliding_log_rate_limiter failed");
    end
    $finish;
  end
endmodule
